FILE: rtl/edbo_pkg.sv
// ----------------------------------------------------------------------------
// edbo_pkg
// Shared constants, types and cell functions for the edit distance t-block.
// ----------------------------------------------------------------------------
package edbo_pkg;

  // block geometry and field widths
  localparam int BLOCK     = 4;
  localparam int CHAR_BITS = 8;
  localparam int CHAR_SLOT = 8;
  localparam int CHARS_W   = 32;
  localparam int OFFS_W    = 8;
  localparam int MISS_W    = BLOCK * BLOCK;

  // cell values stay within -2*BLOCK .. 2*BLOCK, plus sign
  localparam int CELL_W = $clog2(3 * BLOCK + 1) + 1;

  // anti-diagonal split over the three wavefront stages (diagonals 2 .. 2*BLOCK)
  localparam int DIAG_FIRST = 2;
  localparam int DIAG_LAST  = 2 * BLOCK;
  localparam int DIAG_NUM   = 2 * BLOCK - 1;
  localparam int DIAG_A_END = 1 + (DIAG_NUM + 2) / 3;
  localparam int DIAG_B_END = 1 + (2 * DIAG_NUM + 2) / 3;

  // offset codes
  localparam logic [1:0] OFF_ZERO = 2'b00;
  localparam logic [1:0] OFF_POS  = 2'b01;
  localparam logic [1:0] OFF_BAD  = 2'b10;
  localparam logic [1:0] OFF_NEG  = 2'b11;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [BLOCK:0][BLOCK:0][CELL_W-1:0] grid_t;

  // payload carried from stage to stage
  typedef struct packed {
    logic              err;
    logic [MISS_W-1:0] miss;
    grid_t             grid;
  } stage_t;

  localparam cell_t CELL_ONE = cell_t'(1);

  // offset code to cell difference, the bad code counts as zero
  function automatic cell_t decode_off(logic [1:0] code);
    cell_t d;
    case (code)
      OFF_POS: d = CELL_ONE;
      OFF_NEG: d = '1;
      default: d = '0;
    endcase
    return d;
  endfunction

  // cell difference to offset code
  function automatic logic [1:0] encode_diff(cell_t d);
    logic [1:0] code;
    if (d == '0) begin
      code = OFF_ZERO;
    end else if (d[CELL_W-1]) begin
      code = OFF_NEG;
    end else begin
      code = OFF_POS;
    end
    return code;
  endfunction

  // fill every cell whose anti-diagonal r+c lies in lo..hi
  function automatic grid_t wave_step(grid_t g, logic [MISS_W-1:0] miss, int lo, int hi);
    grid_t n;
    cell_t best;
    cell_t up;
    cell_t left;
    n = g;
    for (int r = 1; r <= BLOCK; r++) begin
      for (int c = 1; c <= BLOCK; c++) begin
        if ((r + c) >= lo && (r + c) <= hi) begin
          best = n[r-1][c-1] + cell_t'(miss[(r-1)*BLOCK + (c-1)]);
          up   = n[r-1][c] + CELL_ONE;
          left = n[r][c-1] + CELL_ONE;
          if ($signed(up) < $signed(best)) best = up;
          if ($signed(left) < $signed(best)) best = left;
          n[r][c] = best;
        end
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/edbo_front.sv
// ----------------------------------------------------------------------------
// edbo_front
// Decodes boundary offsets into edge cells, compares characters and flags
// invalid offset codes.
// ----------------------------------------------------------------------------
module edbo_front (
  input  logic [edbo_pkg::CHARS_W-1:0] top_chars_i,
  input  logic [edbo_pkg::CHARS_W-1:0] side_chars_i,
  input  logic [edbo_pkg::OFFS_W-1:0]  top_offsets_i,
  input  logic [edbo_pkg::OFFS_W-1:0]  side_offsets_i,
  output edbo_pkg::stage_t             stage_o
);
  import edbo_pkg::*;

  logic [1:0] top_code;
  logic [1:0] side_code;

  // edges by running sums, mismatch matrix, error flag
  always_comb begin
    stage_o   = '0;
    top_code  = OFF_ZERO;
    side_code = OFF_ZERO;
    for (int i = 1; i <= BLOCK; i++) begin
      top_code  = top_offsets_i[2*(i-1) +: 2];
      side_code = side_offsets_i[2*(i-1) +: 2];
      stage_o.grid[0][i] = stage_o.grid[0][i-1] + decode_off(top_code);
      stage_o.grid[i][0] = stage_o.grid[i-1][0] + decode_off(side_code);
      if (top_code == OFF_BAD || side_code == OFF_BAD) stage_o.err = 1'b1;
    end
    for (int r = 1; r <= BLOCK; r++) begin
      for (int c = 1; c <= BLOCK; c++) begin
        stage_o.miss[(r-1)*BLOCK + (c-1)] =
          top_chars_i[CHAR_SLOT*(c-1) +: CHAR_BITS] != side_chars_i[CHAR_SLOT*(r-1) +: CHAR_BITS];
      end
    end
  end

endmodule

FILE: rtl/edit_distance_block_offsets.sv
// ----------------------------------------------------------------------------
// edit_distance_block_offsets
// One Four Russians t-block of unit-cost edit distance per beat.
// ----------------------------------------------------------------------------
// Throughput: one block per cycle; busy never rises and done_o cannot stall.
// Four register stages: decode and compare, then three anti-diagonal slices
// of the cell wavefront, the last one also encoding the result offsets.
// Reset clears the stage valid bits and done_o; payload registers keep data.
module edit_distance_block_offsets (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [edbo_pkg::CHARS_W-1:0] top_chars_i,
  input  logic [edbo_pkg::CHARS_W-1:0] side_chars_i,
  input  logic [edbo_pkg::OFFS_W-1:0]  top_offsets_i,
  input  logic [edbo_pkg::OFFS_W-1:0]  side_offsets_i,
  output logic                         done_o,
  output logic [edbo_pkg::OFFS_W-1:0]  bottom_offsets_o,
  output logic [edbo_pkg::OFFS_W-1:0]  right_offsets_o,
  output logic                         offset_error_o
);
  import edbo_pkg::*;

  stage_t front;
  stage_t s1_q, s2_q, s3_q;
  stage_t s2_d, s3_d;
  grid_t  last_grid;
  logic [2:0] vld_q;

  logic [OFFS_W-1:0] bottom_d, right_d;
  logic [OFFS_W-1:0] bottom_q, right_q;
  logic              err_q;
  logic              done_q;

  assign busy = 1'b0;

  // decode and compare
  edbo_front u_front (
    .top_chars_i    (top_chars_i),
    .side_chars_i   (side_chars_i),
    .top_offsets_i  (top_offsets_i),
    .side_offsets_i (side_offsets_i),
    .stage_o        (front)
  );

  // wavefront slices
  always_comb begin
    s2_d      = s1_q;
    s2_d.grid = wave_step(s1_q.grid, s1_q.miss, DIAG_FIRST, DIAG_A_END);
    s3_d      = s2_q;
    s3_d.grid = wave_step(s2_q.grid, s2_q.miss, DIAG_A_END + 1, DIAG_B_END);
    last_grid = wave_step(s3_q.grid, s3_q.miss, DIAG_B_END + 1, DIAG_LAST);
  end

  // bottom row and right column differences
  always_comb begin
    bottom_d = '0;
    right_d  = '0;
    for (int i = 0; i < BLOCK; i++) begin
      bottom_d[2*i +: 2] = encode_diff(last_grid[BLOCK][i+1] - last_grid[BLOCK][i]);
      right_d[2*i +: 2]  = encode_diff(last_grid[i+1][BLOCK] - last_grid[i][BLOCK]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[1:0], start & ~busy};
      done_q <= vld_q[2];
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    s1_q     <= front;
    s2_q     <= s2_d;
    s3_q     <= s3_d;
    bottom_q <= bottom_d;
    right_q  <= right_d;
    err_q    <= s3_q.err;
  end

  assign done_o           = done_q;
  assign bottom_offsets_o = bottom_q;
  assign right_offsets_o  = right_q;
  assign offset_error_o   = err_q;

  // true when any 2-bit element holds the bad code
  function automatic logic has_bad(logic [OFFS_W-1:0] v);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < BLOCK; i++) begin
      if (v[2*i +: 2] == OFF_BAD) bad = 1'b1;
    end
    return bad;
  endfunction

  // every result beat matches an earlier accepted start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 4))
    else $error("result beat without matching start");

  // the bad offset code never appears in a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!has_bad(bottom_offsets_o) && !has_bad(right_offsets_o)))
    else $error("bad offset code in result");

  // error flag stays low when the matching start carried no bad offset code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(has_bad(top_offsets_i), 4) && !$past(has_bad(side_offsets_i), 4))
      |-> !offset_error_o)
    else $error("offset error without bad input code");

endmodule

FILE: tb/edbo_checker.sv
// ----------------------------------------------------------------------------
// edbo_checker
// Watches the start and done channels of the t-block. It predicts the
// bottom and right offset vectors and the error flag for every accepted beat,
// and compares them in order with the beats that come out.
// ----------------------------------------------------------------------------
module edbo_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [edbo_pkg::CHARS_W-1:0] top_chars_i,
  input  logic [edbo_pkg::CHARS_W-1:0] side_chars_i,
  input  logic [edbo_pkg::OFFS_W-1:0]  top_offsets_i,
  input  logic [edbo_pkg::OFFS_W-1:0]  side_offsets_i,
  input  logic                         done_o,
  input  logic [edbo_pkg::OFFS_W-1:0]  bottom_offsets_o,
  input  logic [edbo_pkg::OFFS_W-1:0]  right_offsets_o,
  input  logic                         offset_error_o,
  output int                           fail_n,
  output int                           owed_n,
  output int                           results_n,
  output int                           flagged_n
);

  timeunit 1ns;
  timeprecision 1ps;

  import edbo_pkg::*;

  // expected contents of one output beat
  typedef struct packed {
    logic [OFFS_W-1:0] bottom;
    logic [OFFS_W-1:0] right;
    logic              err;
  } tblock_out_t;

  tblock_out_t owed_offsets[$];

  // boundary difference of one 2-bit code, the bad code counts as zero
  function automatic int boundary_step(input logic [1:0] code, inout logic bad);
    int d;
    d = 0;
    case (code)
      OFF_POS:  d = 1;
      OFF_NEG:  d = -1;
      OFF_BAD:  bad = 1'b1;
      default:  d = 0;
    endcase
    return d;
  endfunction

  // fill the whole block and read off its bottom row and right column
  function automatic tblock_out_t tblock_edges(input logic [CHARS_W-1:0] tc,
                                               input logic [CHARS_W-1:0] sc,
                                               input logic [OFFS_W-1:0]  to,
                                               input logic [OFFS_W-1:0]  so);
    int          cost [BLOCK+1][BLOCK+1];
    int          cand;
    int          db;
    int          dr;
    logic        bad;
    tblock_out_t res;
    bad = 1'b0;
    res = '0;
    cost[0][0] = 0;
    for (int i = 1; i <= BLOCK; i++) begin
      cost[0][i] = cost[0][i-1] + boundary_step(to[2*(i-1) +: 2], bad);
      cost[i][0] = cost[i-1][0] + boundary_step(so[2*(i-1) +: 2], bad);
    end
    for (int r = 1; r <= BLOCK; r++) begin
      for (int c = 1; c <= BLOCK; c++) begin
        cand = cost[r-1][c-1] +
               ((tc[(c-1)*CHAR_SLOT +: CHAR_BITS] == sc[(r-1)*CHAR_SLOT +: CHAR_BITS]) ? 0 : 1);
        if (cost[r-1][c] + 1 < cand) cand = cost[r-1][c] + 1;
        if (cost[r][c-1] + 1 < cand) cand = cost[r][c-1] + 1;
        cost[r][c] = cand;
      end
    end
    for (int i = 0; i < BLOCK; i++) begin
      db = cost[BLOCK][i+1] - cost[BLOCK][i];
      dr = cost[i+1][BLOCK] - cost[i][BLOCK];
      res.bottom[2*i +: 2] = (db > 0) ? OFF_POS : (db < 0) ? OFF_NEG : OFF_ZERO;
      res.right[2*i +: 2]  = (dr > 0) ? OFF_POS : (dr < 0) ? OFF_NEG : OFF_ZERO;
    end
    res.err = bad;
    return res;
  endfunction

  initial begin
    fail_n    = 0;
    owed_n    = 0;
    results_n = 0;
    flagged_n = 0;
  end

  // compare the output beat first, then queue the new input beat
  always @(posedge clk_i) begin
    tblock_out_t want;
    if (rst_ni) begin
      if (done_o) begin
        results_n++;
        if (offset_error_o) flagged_n++;
        if (owed_offsets.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("[%0t] unexpected result: bottom=%h right=%h err=%b", $realtime,
                     bottom_offsets_o, right_offsets_o, offset_error_o);
        end else begin
          want = owed_offsets.pop_front();
          if (want.bottom !== bottom_offsets_o || want.right !== right_offsets_o ||
              want.err !== offset_error_o) begin
            fail_n++;
            if (fail_n <= 10)
              $display({"[%0t] mismatch: bottom exp %h got %h, right exp %h got %h,",
                        " err exp %b got %b"},
                       $realtime, want.bottom, bottom_offsets_o, want.right, right_offsets_o,
                       want.err, offset_error_o);
          end
        end
      end
      if (start && !busy)
        owed_offsets.insert(owed_offsets.size(),
                            tblock_edges(top_chars_i, side_chars_i,
                                         top_offsets_i, side_offsets_i));
      owed_n = owed_offsets.size();
    end
  end

endmodule

FILE: tb/tb_edit_distance_block_offsets.sv
// ----------------------------------------------------------------------------
// tb_edit_distance_block_offsets
// Drives t-blocks into the edit distance block: a directed set of boundary
// and character corner cases, then random blocks in phases with and without
// sender gaps. The checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_edit_distance_block_offsets;

  timeunit 1ns;
  timeprecision 1ps;

  import edbo_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 358;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [CHARS_W-1:0] top_chars_i;
  logic [CHARS_W-1:0] side_chars_i;
  logic [OFFS_W-1:0]  top_offsets_i;
  logic [OFFS_W-1:0]  side_offsets_i;
  logic               done_o;
  logic [OFFS_W-1:0]  bottom_offsets_o;
  logic [OFFS_W-1:0]  right_offsets_o;
  logic               offset_error_o;

  int fail_n;
  int owed_n;
  int results_n;
  int flagged_n;
  int sent_n;
  int quiet_cycles = 0;

  edit_distance_block_offsets uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .top_chars_i      (top_chars_i),
    .side_chars_i     (side_chars_i),
    .top_offsets_i    (top_offsets_i),
    .side_offsets_i   (side_offsets_i),
    .done_o           (done_o),
    .bottom_offsets_o (bottom_offsets_o),
    .right_offsets_o  (right_offsets_o),
    .offset_error_o   (offset_error_o)
  );

  edbo_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .top_chars_i      (top_chars_i),
    .side_chars_i     (side_chars_i),
    .top_offsets_i    (top_offsets_i),
    .side_offsets_i   (side_offsets_i),
    .done_o           (done_o),
    .bottom_offsets_o (bottom_offsets_o),
    .right_offsets_o  (right_offsets_o),
    .offset_error_o   (offset_error_o),
    .fail_n           (fail_n),
    .owed_n           (owed_n),
    .results_n        (results_n),
    .flagged_n        (flagged_n)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog on cycles where no beat moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // present one block, hold it until accepted, then maybe leave a gap
  task automatic put_block(input logic [CHARS_W-1:0] tc, input logic [CHARS_W-1:0] sc,
                           input logic [OFFS_W-1:0] to, input logic [OFFS_W-1:0] so,
                           input int idle_pct);
    top_chars_i    <= tc;
    side_chars_i   <= sc;
    top_offsets_i  <= to;
    side_offsets_i <= so;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    sent_n++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // hold off until every queued block has come back
  task automatic drain;
    start <= 1'b0;
    @(negedge clk_i);
    while (owed_n != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int                 idle_pct;
    int                 mode;
    logic [7:0]         base;
    logic [CHARS_W-1:0] tc;
    logic [CHARS_W-1:0] sc;
    logic [OFFS_W-1:0]  to;
    logic [OFFS_W-1:0]  so;
    sent_n         = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    top_chars_i    = '0;
    side_chars_i   = '0;
    top_offsets_i  = '0;
    side_offsets_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all-zero and all-ones strings, uniform and mixed boundaries
    put_block(32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 0);
    put_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'h00, 0);
    put_block(32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 8'h00, 0);
    put_block(32'h5447_4341, 32'h5447_4341, 8'h55, 8'h55, 0);
    put_block(32'h5447_4341, 32'h4143_4754, 8'h55, 8'h55, 0);
    put_block(32'h5447_4341, 32'h4143_4341, 8'hFF, 8'hFF, 0);
    put_block(32'h0102_0304, 32'h0403_0201, 8'h55, 8'hFF, 0);
    put_block(32'h0102_0304, 32'h0403_0201, 8'h73, 8'hCD, 0);
    // chars that differ only in the top bit, and alternating patterns
    put_block(32'h8080_8080, 32'h0000_0000, 8'h55, 8'h55, 0);
    put_block(32'hAAAA_AAAA, 32'h5555_5555, 8'h55, 8'hFF, 0);
    put_block(32'h5555_5555, 32'h5555_5555, 8'h11, 8'h33, 0);
    // bad codes everywhere on each edge
    put_block(32'h1234_5678, 32'h1234_5678, 8'hAA, 8'h55, 0);
    put_block(32'h1234_5678, 32'h8765_4321, 8'h55, 8'hAA, 0);
    put_block(32'hDEAD_BEEF, 32'hBEEF_DEAD, 8'hAA, 8'hAA, 0);
    // a single bad code in each position of each edge
    for (int i = 0; i < BLOCK; i++) begin
      put_block(32'h4142_4344, 32'h4142_4441, OFFS_W'(OFF_BAD) << (2 * i), 8'h55, 0);
      put_block(32'h4142_4344, 32'h4142_4441, 8'h55, OFFS_W'(OFF_BAD) << (2 * i), 0);
    end
    drain();

    // random phases: no gaps, heavy gaps, no gaps, moderate gaps
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       idle_pct = 49;
        3:       idle_pct = 28;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = $urandom_range(9);
        tc   = $urandom;
        sc   = $urandom;
        base = 8'($urandom);
        // small alphabets and near copies so that matches steer the fill
        if (mode <= 3) begin
          for (int k = 0; k < BLOCK; k++) begin
            tc[k*CHAR_SLOT +: 8] = base + 8'($urandom_range(2));
            sc[k*CHAR_SLOT +: 8] = base + 8'($urandom_range(2));
          end
        end else if (mode <= 6) begin
          sc = tc;
          sc[$urandom_range(BLOCK-1)*CHAR_SLOT +: 8] = base;
          if (mode == 6) sc = {sc[CHARS_W-9:0], sc[CHARS_W-1 -: 8]};
        end
        // mostly legal boundary codes, sometimes a bad code or raw bits
        for (int k = 0; k < BLOCK; k++) begin
          case ($urandom_range(2))
            0:       to[2*k +: 2] = OFF_ZERO;
            1:       to[2*k +: 2] = OFF_POS;
            default: to[2*k +: 2] = OFF_NEG;
          endcase
          case ($urandom_range(2))
            0:       so[2*k +: 2] = OFF_ZERO;
            1:       so[2*k +: 2] = OFF_POS;
            default: so[2*k +: 2] = OFF_NEG;
          endcase
        end
        case ($urandom_range(19))
          0:       to[2*$urandom_range(BLOCK-1) +: 2] = OFF_BAD;
          1:       so[2*$urandom_range(BLOCK-1) +: 2] = OFF_BAD;
          2:       to = OFFS_W'($urandom);
          3:       so = OFFS_W'($urandom);
          default: ;
        endcase
        put_block(tc, sc, to, so, idle_pct);
        if (n == PHASE_ITEMS / 2 && ph == 1) drain();
      end
      drain();
    end

    // let the pipeline settle
    start <= 1'b0;
    @(negedge clk_i);
    while (owed_n != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d blocks, %0d results checked, %0d flagged for bad offset codes",
             sent_n, results_n, flagged_n);
    $display("directed edge and bad-code cases plus random phases with 0, 49 and 28 pct gaps");
    if (fail_n == 0 && owed_n == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
